>>> sv/tss_pkg.sv
// Shared types, constants and the digit font for the temperature scanner.
package tss_pkg;

  localparam int unsigned TempWidth  = 12;
  localparam int unsigned SegWidth   = 7;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned PosWidth   = 2;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  localparam logic [SegWidth-1:0] SegMinus = 7'h40;
  localparam logic [SegWidth-1:0] SegBlank = 7'h00;

  // Command carried on the input tuser bit.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  // Scan positions of the four digits.
  typedef enum logic [PosWidth-1:0] {
    POS_SIGN   = 2'd0,
    POS_TENS   = 2'd1,
    POS_UNITS  = 2'd2,
    POS_TENTHS = 2'd3
  } pos_e;

  // One driven digit as it leaves the decoder.
  typedef struct packed {
    logic [NumDigits-1:0] digit_enables;
    logic                 decimal_point;
    logic [SegWidth-1:0]  segments;
  } disp_t;

  // Active-high segment pattern for a decimal digit, bit 0 = a.
  function automatic logic [SegWidth-1:0] digit_font(input logic [3:0] digit);
    logic [SegWidth-1:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

>>> sv/tss_digit_decode.sv
// Combinational decode of the held temperature into one multiplexed digit.
module tss_digit_decode (
  input  logic signed [tss_pkg::TempWidth-1:0] temp_i,
  input  tss_pkg::pos_e                        pos_i,
  output tss_pkg::disp_t                       disp_o
);

  logic                              neg;
  logic [tss_pkg::TempWidth-1:0]     mag;
  logic [7:0]                        whole;
  logic [3:0]                        frac;
  logic [15:0]                       recip_prod;
  logic [3:0]                        quot;
  logic [3:0]                        tens;
  logic [7:0]                        units_full;
  logic [3:0]                        units;
  logic [7:0]                        frac_x10;
  logic [3:0]                        tenths;

  // Magnitude in Q.4; the most negative value yields 0x800, which still fits.
  assign neg   = temp_i[tss_pkg::TempWidth-1];
  assign mag   = neg ? (~temp_i + 12'd1) : temp_i;
  assign whole = mag[11:4];
  assign frac  = mag[3:0];

  // whole / 10 as a multiply by 205/2048, exact for every value whole can take (0 to 128).
  assign recip_prod = 16'(whole) * 16'd205;
  assign quot       = recip_prod[14:11];
  assign tens       = (quot >= 4'd10) ? (quot - 4'd10) : quot;
  assign units_full = whole - {1'b0, quot, 3'b000} - {3'b000, quot, 1'b0};
  assign units      = units_full[3:0];

  // Tenths are floor(10 * frac / 16).
  assign frac_x10 = {1'b0, frac, 3'b000} + {3'b000, frac, 1'b0};
  assign tenths   = frac_x10[7:4];

  always_comb begin
    disp_o.decimal_point = 1'b0;
    disp_o.digit_enables = ~(tss_pkg::NumDigits'(1) << pos_i);
    unique case (pos_i)
      tss_pkg::POS_SIGN: begin
        disp_o.segments = neg ? tss_pkg::SegMinus : tss_pkg::SegBlank;
      end
      tss_pkg::POS_TENS: begin
        disp_o.segments = tss_pkg::digit_font(tens);
      end
      tss_pkg::POS_UNITS: begin
        disp_o.segments      = tss_pkg::digit_font(units);
        disp_o.decimal_point = 1'b1;
      end
      tss_pkg::POS_TENTHS: begin
        disp_o.segments = tss_pkg::digit_font(tenths);
      end
      default: begin
        disp_o.segments = tss_pkg::SegBlank;
      end
    endcase
  end

endmodule

>>> sv/temperature_seven_segment_scanner.sv
// Top level of the multiplexed four-digit temperature display scanner.
//
// The block holds a signed temperature in sixteenths of a degree and a scan
// position. Words arrive on the s_axis channel. When tuser is high the word
// is a load: tdata carries the new temperature, it is stored, and no output
// word is produced. When tuser is low the word is a scan tick: the digit at
// the current scan position is decoded and sent on m_axis, and the scan
// position advances through sign, tens, units and tenths.
// Each tick yields exactly one output word, registered on the edge that
// accepts it; a load takes effect for a tick accepted in the very next cycle.
// The decode sits between the held temperature register and a single
// output register, so one word can be accepted every cycle while the receiver keeps up.
// When the receiver stalls with a result waiting, s_axis_tready drops and
// the pending result stays put; it rises again in the cycle the receiver
// takes that word, so the stream keeps its full rate.
// Reset clears the held temperature to zero, the scan position to the sign
// digit and the output valid flag.
module temperature_seven_segment_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits 11:0 temperature (signed), bits 15:12 zero.
  input  logic [tss_pkg::InDataW-1:0] s_axis_tdata,
  // Bit 0 command: 0 scan tick, 1 load.
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits 6:0 segments, bit 7 decimal_point, bits 11:8 digit_enables,
  // bits 15:12 zero.
  output logic [tss_pkg::OutDataW-1:0] m_axis_tdata
);

  logic signed [tss_pkg::TempWidth-1:0] temp_q, temp_d;
  tss_pkg::pos_e                        pos_q, pos_d;
  logic                                 out_valid_q, out_valid_d;
  tss_pkg::disp_t                       disp_q, disp_d;
  tss_pkg::disp_t                       disp;
  logic                                 in_fire;
  logic                                 is_load;
  logic                                 is_tick;

  // The output register may be refilled in the cycle its word is taken.
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign is_load       = in_fire & (tss_pkg::cmd_e'(s_axis_tuser) == tss_pkg::CMD_LOAD);
  assign is_tick       = in_fire & (tss_pkg::cmd_e'(s_axis_tuser) == tss_pkg::CMD_TICK);

  tss_digit_decode u_decode (
    .temp_i (temp_q),
    .pos_i  (pos_q),
    .disp_o (disp)
  );

  always_comb begin
    temp_d      = temp_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    disp_d      = disp_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (is_load) begin
      temp_d = s_axis_tdata[tss_pkg::TempWidth-1:0];
    end
    if (is_tick) begin
      // Scan position wraps naturally at four digits.
      pos_d       = tss_pkg::pos_e'(pos_q + tss_pkg::PosWidth'(1));
      out_valid_d = 1'b1;
      disp_d      = disp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q      <= '0;
      pos_q       <= tss_pkg::POS_SIGN;
      out_valid_q <= 1'b0;
    end else begin
      temp_q      <= temp_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    disp_q <= disp_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, disp_q};

endmodule

>>> bench/scanner_digit_checker.sv
// Checker that predicts the driven digit for each scan tick and compares it.
module scanner_digit_checker
  import tss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // Bits 11:0 temperature (signed), bits 15:12 zero.
  input  logic [InDataW-1:0]  s_tdata_i,
  // Bit 0 command: 0 scan tick, 1 load.
  input  logic                s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // Bits 6:0 segments, bit 7 decimal_point, bits 11:8 digit_enables, bits 15:12 zero.
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  error_count_o,
  output int                  pending_o
);

  // Glyphs for 0..9, digit n in bits 7n+6:7n.
  localparam logic [10*SegWidth-1:0] Glyphs = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  logic [TempWidth-1:0] shown_temp;
  pos_e                 scan_pos;
  disp_t                expected_digits[$];
  int                   errors;

  assign error_count_o = errors;
  assign pending_o     = expected_digits.size();

  function automatic logic [SegWidth-1:0] glyph(input int value);
    return Glyphs[value*SegWidth +: SegWidth];
  endfunction

  // The digit that a tick shows for a given temperature and scan position.
  function automatic disp_t predict_digit(input logic [TempWidth-1:0] temp, input pos_e pos);
    disp_t      d;
    logic [12:0] mag;
    int         whole;
    int         frac;
    mag   = temp[TempWidth-1] ? 13'h1000 - {1'b0, temp} : {1'b0, temp};
    whole = int'(mag[12:4]);
    frac  = int'(mag[3:0]);
    d.decimal_point = 1'b0;
    d.digit_enables = ~(4'b0001 << pos);
    case (pos)
      POS_SIGN:  d.segments = temp[TempWidth-1] ? SegMinus : SegBlank;
      POS_TENS:  d.segments = glyph((whole / 10) % 10);
      POS_UNITS: begin
        d.segments      = glyph(whole % 10);
        d.decimal_point = 1'b1;
      end
      default:   d.segments = glyph((frac * 10) >> 4);
    endcase
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    disp_t want;
    disp_t got;
    if (!rst_ni) begin
      shown_temp = '0;
      scan_pos   = POS_SIGN;
      expected_digits.delete();
    end else begin
      // Compare first, so a word can never be matched against a tick of the same edge.
      if (m_tvalid_i && m_tready_i) begin
        got = disp_t'(m_tdata_i[SegWidth+NumDigits:0]);
        if (expected_digits.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata_i));
        end else begin
          want = expected_digits.pop_front();
          if (got.segments != want.segments)
            report_mismatch($sformatf("segments %h, want %h", got.segments, want.segments));
          if (got.decimal_point != want.decimal_point)
            report_mismatch($sformatf("decimal_point %b, want %b",
                                      got.decimal_point, want.decimal_point));
          if (got.digit_enables != want.digit_enables)
            report_mismatch($sformatf("digit_enables %b, want %b",
                                      got.digit_enables, want.digit_enables));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (cmd_e'(s_tuser_i) == CMD_LOAD) begin
          shown_temp = s_tdata_i[TempWidth-1:0];
        end else begin
          expected_digits.push_back(predict_digit(shown_temp, scan_pos));
          scan_pos = pos_e'(2'(scan_pos + 2'd1));
        end
      end
    end
  end

endmodule

>>> bench/temperature_seven_segment_scanner_test.sv
// Stimulus and verdict for the temperature scanner; checking sits in the checker.
module temperature_seven_segment_scanner_test;
  import tss_pkg::*;

  // Even the slowest correct run (both sides drawing their longest idle on
  // every word) stays far below this limit, so the limit only catches hangs.
  localparam int unsigned CycleLimit = 200000;
  localparam int          RandomWords = 600;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // Bits 11:0 temperature (signed), bits 15:12 zero.
  logic [InDataW-1:0]  s_axis_tdata;
  // Bit 0 command: 0 scan tick, 1 load.
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // Bits 6:0 segments, bit 7 decimal_point, bits 11:8 digit_enables, bits 15:12 zero.
  logic [OutDataW-1:0] m_axis_tdata;

  int          error_count;
  int          pending_digits;
  int unsigned cycle_count = 0;
  // When set, neither side inserts idle cycles, so the stream runs at full rate.
  bit          full_rate = 1'b0;

  temperature_seven_segment_scanner DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  scanner_digit_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_digits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one word after a random gap and holds it until the block takes it.
  // The task returns right after the accepting edge; the next call moves on at
  // the following falling edge, so valid stays high across back-to-back words.
  task automatic send_word(input cmd_e cmd, input logic [TempWidth-1:0] temp);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {{(InDataW-TempWidth){1'b0}}, temp};
    s_axis_tuser  <= cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Load a temperature, then scan a number of digits.
  task automatic show(input logic [TempWidth-1:0] temp, input int ticks);
    send_word(CMD_LOAD, temp);
    repeat (ticks) send_word(CMD_TICK, TempWidth'($urandom));
  endtask

  // The sender holds off until every digit already asked for has come out.
  task automatic drain_display;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_digits != 0) @(negedge clk_i);
  endtask

  // Receiver: for every word it draws a stall, then takes the word.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = full_rate ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    logic [TempWidth-1:0] temp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Two ticks straight out of reset show the reset value of
    // zero: a blank sign and a zero tens digit.
    send_word(CMD_TICK, 12'h000);
    send_word(CMD_TICK, 12'hFFF);
    // The scan is now at the units digit; a load must not move it.
    show(12'h800, 4);   // most negative value reads as minus 128.0, tens shows 2
    show(12'h7FF, 4);   // largest value, 127.9375, tenths 9
    show(12'hFFF, 2);   // minus one sixteenth, scanned at the units and tenths digits only
    show(12'h000, 2);   // load at the sign digit, positive zero
    show(12'h0A8, 4);   // 10.5 degrees
    drain_display;

    // Random part. Every third stretch of 60 words runs with no idling on
    // either side; the rest idles at random. Ticks dominate so the display
    // scans through each temperature several times.
    for (int i = 0; i < RandomWords; i++) begin
      full_rate = ((i / 60) % 3) == 1;
      if (i == RandomWords / 2) drain_display;
      case ($urandom_range(0, 7))
        0:       temp = 12'h800;
        1:       temp = 12'h7FF;
        2:       temp = TempWidth'($urandom_range(0, 31)) ^ {TempWidth{$urandom_range(0, 1) == 1}};
        default: temp = TempWidth'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) send_word(CMD_LOAD, temp);
      else send_word(CMD_TICK, temp);
    end

    // Wait for every digit, then a few cycles more for any stray word.
    drain_display;
    repeat (5) @(negedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> temperature_seven_segment_scanner.f
sv/tss_pkg.sv
sv/tss_digit_decode.sv
sv/temperature_seven_segment_scanner.sv
bench/scanner_digit_checker.sv
bench/temperature_seven_segment_scanner_test.sv
